/* hw/rtl/ptom_pkg.sv */
// Shared types and codes for the price-time order book matcher.
package ptom_pkg;

   localparam int IDX_W = 6;
   localparam int PRICE_W = 32;
   localparam int QTY_W = 32;
   localparam int ID_W = 32;
   localparam int SEQ_W = 48;

   localparam logic MODE_SUBMIT = 1'b0;
   localparam logic MODE_CANCEL = 1'b1;

   localparam logic SIDE_BUY = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   localparam logic [1:0] KIND_TRADE = 2'd0;
   localparam logic [1:0] KIND_SUBMIT = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   localparam logic [2:0] STAT_FILLED = 3'd0;
   localparam logic [2:0] STAT_RESTED = 3'd1;
   localparam logic [2:0] STAT_FULL = 3'd2;
   localparam logic [2:0] STAT_CANCELLED = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

   typedef enum logic [2:0] {
      SCAN_NONE,
      SCAN_MATCH,
      SCAN_OWNER,
      SCAN_BEST,
      SCAN_FREE
   } scan_type;

   // Search command broadcast to every cell of one row.
   typedef struct packed {
      scan_type         scan;
      logic [ID_W-1:0]  key;
   } op_type;

   // Candidate entry handed from cell to cell along the row.
   typedef struct packed {
      logic               valid;
      logic [IDX_W-1:0]   idx;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [ID_W-1:0]    owner;
      logic [SEQ_W-1:0]   seq;
   } cand_type;

   // Entry update broadcast to one row.
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   idx;
      logic               load;
      logic               used;
      logic [QTY_W-1:0]   qty;
      logic [PRICE_W-1:0] price;
      logic [ID_W-1:0]    owner;
      logic [SEQ_W-1:0]   seq;
   } wr_type;

endpackage

/* hw/rtl/ptom_cell.sv */
// One book slot: holds an entry and folds it into the passing candidate.
module ptom_cell import ptom_pkg::*; #(
   parameter bit IS_BID = 1'b1,
   parameter int IDX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  op_type   op,
   input  wr_type   wr,
   input  cand_type cand_in,
   output cand_type cand_out
);

   logic               used_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic [ID_W-1:0]    owner_ff;
   logic [SEQ_W-1:0]   seq_ff;
   cand_type           cand_ff;
   cand_type           cand_in_mine;
   logic               elig;
   logic               better;
   logic               price_better;
   logic               hit;

   assign hit = wr.en && (wr.idx == IDX_W'(IDX));

   always_comb begin
      price_better = IS_BID ? (price_ff > cand_in.price) : (price_ff < cand_in.price);
      elig = 1'b0;
      better = 1'b0;
      case (op.scan)
         SCAN_MATCH: begin
            elig = used_ff && (IS_BID ? (price_ff >= op.key) : (price_ff <= op.key));
            better = !cand_in.valid || price_better ||
                     ((price_ff == cand_in.price) && (seq_ff < cand_in.seq));
         end
         SCAN_OWNER: begin
            elig = used_ff && (owner_ff == op.key);
            better = !cand_in.valid || (seq_ff < cand_in.seq);
         end
         SCAN_BEST: begin
            elig = used_ff;
            better = !cand_in.valid || price_better;
         end
         SCAN_FREE: begin
            elig = !used_ff;
            better = !cand_in.valid;
         end
         default: begin
            elig = 1'b0;
            better = 1'b0;
         end
      endcase
      cand_in_mine.valid = 1'b1;
      cand_in_mine.idx = IDX_W'(IDX);
      cand_in_mine.price = price_ff;
      cand_in_mine.qty = qty_ff;
      cand_in_mine.owner = owner_ff;
      cand_in_mine.seq = seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         cand_ff.valid <= 1'b0;
      end else begin
         if (hit) begin
            used_ff <= wr.used;
         end
         cand_ff.valid <= (elig && better) ? 1'b1 : cand_in.valid;
      end
      if (hit) begin
         qty_ff <= wr.qty;
         if (wr.load) begin
            price_ff <= wr.price;
            owner_ff <= wr.owner;
            seq_ff <= wr.seq;
         end
      end
      if (elig && better) begin
         cand_ff.idx <= cand_in_mine.idx;
         cand_ff.price <= cand_in_mine.price;
         cand_ff.qty <= cand_in_mine.qty;
         cand_ff.owner <= cand_in_mine.owner;
         cand_ff.seq <= cand_in_mine.seq;
      end else begin
         cand_ff.idx <= cand_in.idx;
         cand_ff.price <= cand_in.price;
         cand_ff.qty <= cand_in.qty;
         cand_ff.owner <= cand_in.owner;
         cand_ff.seq <= cand_in.seq;
      end
   end

   assign cand_out = cand_ff;

endmodule

/* hw/rtl/ptom_row.sv */
// One side of the book: a chain of slot cells with a registered candidate between each.
module ptom_row import ptom_pkg::*; #(
   parameter int BOOK_DEPTH = 32,
   parameter bit IS_BID = 1'b1
) (
   input  logic     clock,
   input  logic     reset,
   input  op_type   op,
   input  wr_type   wr,
   output cand_type result
);

   cand_type chain [BOOK_DEPTH+1];

   assign chain[0] = '0;

   for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
      ptom_cell #(
         .IS_BID(IS_BID),
         .IDX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .op(op),
         .wr(wr),
         .cand_in(chain[i]),
         .cand_out(chain[i+1])
      );
   end

   assign result = chain[BOOK_DEPTH];

endmodule

/* hw/rtl/price_time_order_book_matcher_core.sv */
// Top level of the price-time priority order book matcher.
//
// A request is taken at a rising edge where start is high and busy is low.
// A submit (req_mode 0) matches against the opposite side, emitting one
// trade per resting order hit, then rests or refuses the remainder. A
// cancel (req_mode 1) removes the earliest-sequence entry with the id,
// bids first. Every request ends with one summary carrying rsp_last.
// Each result is shown for exactly one cycle with rsp_strobe high; the
// receiver cannot stall, so results are never held back.
// Each side is a chain of BOOK_DEPTH slot cells. A search walks a
// candidate down the chain one cell per cycle. A submit costs one search
// per trade; a remainder adds one match search that finds nothing and one
// free-slot search; the summary needs one best-price search, and a
// zero-quantity submit needs only that one. A cancel costs two searches.
// The summary shows in the cycle after the last search, and the next
// request is taken at the edge ending it.
// Synchronous reset empties both sides and clears the sequence counter;
// no clearing pass is needed since only slots marked used are ever read.
module price_time_order_book_matcher_core import ptom_pkg::*; #(
   parameter int BOOK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [ID_W-1:0]    req_order_id,
   input  logic               req_side,
   input  logic [PRICE_W-1:0] req_limit_price,
   input  logic [QTY_W-1:0]   req_order_qty,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_kind,
   output logic [ID_W-1:0]    rsp_maker_id,
   output logic [ID_W-1:0]    rsp_taker_id,
   output logic [PRICE_W-1:0] rsp_trade_price,
   output logic [QTY_W-1:0]   rsp_amount,
   output logic [SEQ_W-1:0]   rsp_trade_seq,
   output logic [2:0]         rsp_status,
   output logic [PRICE_W-1:0] rsp_top_bid,
   output logic               rsp_top_bid_valid,
   output logic [PRICE_W-1:0] rsp_top_ask,
   output logic               rsp_top_ask_valid,
   output logic               rsp_last
);

   localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SLOT,
      ST_CANCEL,
      ST_BEST
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [SEQ_W-1:0]   own_seq_ff;
   logic               mode_ff;
   logic [ID_W-1:0]    id_ff;
   logic               side_ff;
   logic [PRICE_W-1:0] limit_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic [2:0]         status_ff;

   logic               strobe_ff;
   logic [1:0]         kind_ff;
   logic [ID_W-1:0]    maker_ff;
   logic [ID_W-1:0]    taker_ff;
   logic [PRICE_W-1:0] tprice_ff;
   logic [QTY_W-1:0]   amount_ff;
   logic [SEQ_W-1:0]   tseq_ff;
   logic [2:0]         rstatus_ff;
   logic [PRICE_W-1:0] bbid_ff;
   logic               bbid_v_ff;
   logic [PRICE_W-1:0] bask_ff;
   logic               bask_v_ff;
   logic               last_ff;

   op_type   op_bid;
   op_type   op_ask;
   wr_type   wr_bid;
   wr_type   wr_ask;
   wr_type   wr_cmd;
   logic     wr_to_bid;
   cand_type bid_res;
   cand_type ask_res;
   cand_type opp_res;
   cand_type own_res;

   logic               done;
   logic [QTY_W-1:0]   fill;
   logic [QTY_W-1:0]   remain;
   logic [QTY_W-1:0]   left_over;

   ptom_row #(.BOOK_DEPTH(BOOK_DEPTH), .IS_BID(1'b1)) u_bid (
      .clock(clock), .reset(reset), .op(op_bid), .wr(wr_bid), .result(bid_res)
   );

   ptom_row #(.BOOK_DEPTH(BOOK_DEPTH), .IS_BID(1'b0)) u_ask (
      .clock(clock), .reset(reset), .op(op_ask), .wr(wr_ask), .result(ask_res)
   );

   // A search result is complete once the candidate has passed every cell.
   assign done = (cnt_ff == CNT_W'(BOOK_DEPTH));
   // A buy searches the asks and a sell the bids.
   assign opp_res = (side_ff == SIDE_SELL) ? bid_res : ask_res;
   assign own_res = (side_ff == SIDE_SELL) ? ask_res : bid_res;
   assign fill = (qty_ff < opp_res.qty) ? qty_ff : opp_res.qty;
   assign remain = qty_ff - fill;
   assign left_over = opp_res.qty - fill;

   // Search commands follow the controller state.
   always_comb begin
      op_bid.scan = SCAN_NONE;
      op_ask.scan = SCAN_NONE;
      op_bid.key = limit_ff;
      op_ask.key = limit_ff;
      case (state_ff)
         ST_MATCH: begin
            if (side_ff == SIDE_SELL) begin
               op_bid.scan = SCAN_MATCH;
            end else begin
               op_ask.scan = SCAN_MATCH;
            end
         end
         ST_SLOT: begin
            if (side_ff == SIDE_SELL) begin
               op_ask.scan = SCAN_FREE;
            end else begin
               op_bid.scan = SCAN_FREE;
            end
         end
         ST_CANCEL: begin
            op_bid.scan = SCAN_OWNER;
            op_ask.scan = SCAN_OWNER;
            op_bid.key = id_ff;
            op_ask.key = id_ff;
         end
         ST_BEST: begin
            op_bid.scan = SCAN_BEST;
            op_ask.scan = SCAN_BEST;
         end
         default: begin
            op_bid.scan = SCAN_NONE;
            op_ask.scan = SCAN_NONE;
         end
      endcase
   end

   // Entry updates land at the same edge that ends the search deciding them.
   always_comb begin
      wr_cmd.en = 1'b0;
      wr_cmd.idx = opp_res.idx;
      wr_cmd.load = 1'b0;
      wr_cmd.used = 1'b0;
      wr_cmd.qty = left_over;
      wr_cmd.price = limit_ff;
      wr_cmd.owner = id_ff;
      wr_cmd.seq = own_seq_ff;
      wr_to_bid = (side_ff == SIDE_SELL);
      case (state_ff)
         ST_MATCH: begin
            wr_cmd.en = done && opp_res.valid;
            wr_cmd.used = (left_over != '0);
         end
         ST_SLOT: begin
            wr_to_bid = (side_ff == SIDE_BUY);
            wr_cmd.en = done && own_res.valid;
            wr_cmd.idx = own_res.idx;
            wr_cmd.load = 1'b1;
            wr_cmd.used = 1'b1;
            wr_cmd.qty = qty_ff;
         end
         ST_CANCEL: begin
            wr_to_bid = bid_res.valid;
            wr_cmd.en = done && (bid_res.valid || ask_res.valid);
            wr_cmd.idx = bid_res.valid ? bid_res.idx : ask_res.idx;
            wr_cmd.qty = bid_res.valid ? bid_res.qty : ask_res.qty;
         end
         default: begin
            wr_cmd.en = 1'b0;
         end
      endcase
      wr_bid = wr_cmd;
      wr_ask = wr_cmd;
      wr_bid.en = wr_cmd.en && wr_to_bid;
      wr_ask.en = wr_cmd.en && !wr_to_bid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         seq_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (start) begin
                  mode_ff <= req_mode;
                  id_ff <= req_order_id;
                  side_ff <= req_side;
                  limit_ff <= req_limit_price;
                  qty_ff <= req_order_qty;
                  if (req_mode == MODE_SUBMIT) begin
                     own_seq_ff <= seq_ff;
                     seq_ff <= seq_ff + SEQ_W'(1);
                     if (req_order_qty != '0) begin
                        state_ff <= ST_MATCH;
                     end else begin
                        status_ff <= STAT_FILLED;
                        state_ff <= ST_BEST;
                     end
                  end else begin
                     state_ff <= ST_CANCEL;
                  end
               end
            end
            ST_MATCH: begin
               if (!done) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end else begin
                  cnt_ff <= '0;
                  if (opp_res.valid) begin
                     strobe_ff <= 1'b1;
                     kind_ff <= KIND_TRADE;
                     maker_ff <= opp_res.owner;
                     taker_ff <= id_ff;
                     tprice_ff <= opp_res.price;
                     amount_ff <= fill;
                     tseq_ff <= seq_ff;
                     rstatus_ff <= STAT_FILLED;
                     bbid_ff <= '0;
                     bbid_v_ff <= 1'b0;
                     bask_ff <= '0;
                     bask_v_ff <= 1'b0;
                     last_ff <= 1'b0;
                     seq_ff <= seq_ff + SEQ_W'(1);
                     qty_ff <= remain;
                     if (remain == '0) begin
                        status_ff <= STAT_FILLED;
                        state_ff <= ST_BEST;
                     end
                  end else begin
                     state_ff <= ST_SLOT;
                  end
               end
            end
            ST_SLOT: begin
               if (!done) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end else begin
                  cnt_ff <= '0;
                  status_ff <= own_res.valid ? STAT_RESTED : STAT_FULL;
                  state_ff <= ST_BEST;
               end
            end
            ST_CANCEL: begin
               if (!done) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end else begin
                  cnt_ff <= '0;
                  status_ff <= (bid_res.valid || ask_res.valid) ?
                               STAT_CANCELLED : STAT_NOT_FOUND;
                  state_ff <= ST_BEST;
               end
            end
            ST_BEST: begin
               if (!done) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end else begin
                  cnt_ff <= '0;
                  strobe_ff <= 1'b1;
                  kind_ff <= (mode_ff == MODE_CANCEL) ? KIND_CANCEL : KIND_SUBMIT;
                  maker_ff <= '0;
                  taker_ff <= id_ff;
                  tprice_ff <= '0;
                  amount_ff <= (mode_ff == MODE_CANCEL) ? '0 : qty_ff;
                  tseq_ff <= '0;
                  rstatus_ff <= status_ff;
                  bbid_ff <= bid_res.valid ? bid_res.price : '0;
                  bbid_v_ff <= bid_res.valid;
                  bask_ff <= ask_res.valid ? ask_res.price : '0;
                  bask_v_ff <= ask_res.valid;
                  last_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_kind = kind_ff;
   assign rsp_maker_id = maker_ff;
   assign rsp_taker_id = taker_ff;
   assign rsp_trade_price = tprice_ff;
   assign rsp_amount = amount_ff;
   assign rsp_trade_seq = tseq_ff;
   assign rsp_status = rstatus_ff;
   assign rsp_top_bid = bbid_ff;
   assign rsp_top_bid_valid = bbid_v_ff;
   assign rsp_top_ask = bask_ff;
   assign rsp_top_ask_valid = bask_v_ff;
   assign rsp_last = last_ff;

endmodule
